[hdl/modular_exponentiation_top_macros.svh]
// Assertion macros for the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/modexp_pkg.sv]
// Types and constants for the modular exponentiation block.
package modexp_pkg;

   localparam int RESIDUE_WIDTH = 32;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_LAUNCH = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

[hdl/modexp_mulmod.sv]
// Bit-serial modular multiplier: r = a * b mod m, multiplier bits MSB first.
module modexp_mulmod #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] result
);
   import modexp_pkg::*;

   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  b_ff, b_in;
   logic [CW-1:0] count_ff, count_in;
   logic          phase_ff, phase_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W-1:0]  sum;

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] md);
      logic [W:0] t;
      logic [W:0] d;
      t = {1'b0, x} + {1'b0, y};
      d = t - {1'b0, md};
      if (t >= {1'b0, md}) begin
         return d[W-1:0];
      end
      return t[W-1:0];
   endfunction

   assign sum = add_mod(r_ff, phase_ff ? a : r_ff, m);

   always_comb begin
      r_in     = r_ff;
      b_in     = b_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         r_in     = '0;
         b_in     = b;
         count_in = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            r_in     = sum;
            phase_in = 1'b1;
         end else begin
            if (b_ff[W-1]) begin
               r_in = sum;
            end
            b_in     = {b_ff[W-2:0], 1'b0};
            phase_in = 1'b0;
            count_in = count_ff + 1'b1;
            if (count_ff == CW'(W - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      b_ff     <= b_in;
      count_ff <= count_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

[hdl/modular_exponentiation_top.sv]
// Modular exponentiation: residue = base_value ** power mod divisor, right-to-left.
//
// Request channel (req_*): base, exponent and modulus, taken on valid and ready.
// Response channel (rsp_*): residue and zero-modulus flag, one per request.
// One request is worked on at a time; req_ready is high only while idle.
// A zero divisor skips the multiplies and answers with residue 0 and the error flag set.
// Otherwise the base is first reduced by one bit-serial modular multiply,
// then each exponent bit up to the highest set one is handled by a pair of
// multiplies: the accumulator multiply and the squaring run side by side on
// two bit-serial multipliers, each taking a doubling step and then an add
// step per multiplier bit.
// The next request is taken the cycle after the response is loaded.
// The finished response sits in an output register, so the next request is
// taken while it waits; when the receiver stalls and a second result is
// ready, the block holds it until the register frees.
// Synchronous reset empties the output register and returns to idle.
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [OPERAND_WIDTH-1:0]             req_base_value,
   input  logic [OPERAND_WIDTH-1:0]             req_power,
   input  logic [OPERAND_WIDTH-1:0]             req_divisor,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [modexp_pkg::RESIDUE_WIDTH-1:0] rsp_residue,
   output logic                                 rsp_zero_modulus_error
);
   import modexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   state_type              state_ff, state_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           bval_ff, bval_in;
   logic [W-1:0]           exp_ff, exp_in;
   logic [W-1:0]           mod_ff, mod_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESIDUE_WIDTH-1:0] rsp_residue_ff, rsp_residue_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   start0, start1;
   logic [W-1:0]           b0;
   logic                   done0, done1;
   logic [W-1:0]           res0, res1;
   logic [W-1:0]           exp_next;

   modexp_mulmod #(.W(W)) u_mul_acc (
      .clock  (clock),
      .reset  (reset),
      .start  (start0),
      .a      (acc_ff),
      .b      (b0),
      .m      (mod_ff),
      .done   (done0),
      .result (res0)
   );

   modexp_mulmod #(.W(W)) u_mul_sq (
      .clock  (clock),
      .reset  (reset),
      .start  (start1),
      .a      (bval_ff),
      .b      (bval_ff),
      .m      (mod_ff),
      .done   (done1),
      .result (res1)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign exp_next  = exp_ff >> 1;

   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      bval_in        = bval_ff;
      exp_in         = exp_ff;
      mod_in         = mod_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_residue_in = rsp_residue_ff;
      rsp_err_in     = rsp_err_ff;
      start0         = 1'b0;
      start1         = 1'b0;
      b0             = bval_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mod_in = req_divisor;
               exp_in = req_power;
               err_in = (req_divisor == '0);
               if (req_divisor == '0) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = W'(1);
                  start0   = 1'b1;
                  b0       = req_base_value;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (done0) begin
               bval_in  = res0;
               state_in = (exp_ff == '0) ? ST_FINISH : ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            start0   = 1'b1;
            start1   = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (done0) begin
               if (exp_ff[0]) begin
                  acc_in = res0;
               end
               bval_in  = res1;
               exp_in   = exp_next;
               state_in = (exp_next == '0) ? ST_FINISH : ST_LAUNCH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_residue_in = RESIDUE_WIDTH'(acc_ff);
               rsp_err_in     = err_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      bval_ff        <= bval_in;
      exp_ff         <= exp_in;
      mod_ff         <= mod_in;
      err_ff         <= err_in;
      rsp_residue_ff <= rsp_residue_in;
      rsp_err_ff     <= rsp_err_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_residue            = rsp_residue_ff;
   assign rsp_zero_modulus_error = rsp_err_ff;

   `MODEXP_ASSERT_NOW(a_mul_in_step, (state_ff == ST_SCAN) && done0, done1,
                      "multipliers out of step")
   `MODEXP_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_err_ff, rsp_residue_ff == '0,
                      "error with nonzero residue")
   `MODEXP_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE,
                       "request accepted but idle")
   `MODEXP_ASSERT_NOW(a_no_stray_done, (state_ff == ST_IDLE) || (state_ff == ST_FINISH),
                      !done0 && !done1, "multiplier done outside a multiply")

endmodule
